// ===== rtl/dsdl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdl_pkg: shared types for the depth sorted draw list
// Key width, controller state encoding and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dsdl_pkg;

	localparam int KEY_WIDTH = 16;

	typedef logic signed [KEY_WIDTH-1:0] key_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;
		logic drop;
		logic pop;
	} dp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic one_left;
	} dp_status_t;

endpackage

// ===== rtl/dsdl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdl_ctrl: controller of the depth sorted draw list
// Runs the input and output handshakes, decides between insert, drop and
// drain, and steps a drain one record per free output slot.
// ----------------------------------------------------------------------------
module dsdl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  dsdl_pkg::dp_status_t status_i,
	output dsdl_pkg::dp_cmd_t    cmd
);

	dsdl_pkg::state_t state_q;
	dsdl_pkg::state_t state_d;
	logic             out_valid_q;
	logic             slot_free;
	logic             accept;
	logic             start_drain;

	// The output register can take a new beat when it is empty or being emptied.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == dsdl_pkg::ST_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.insert  = accept && !mode && !status_i.full;
		cmd.drop    = accept && !mode && status_i.full;
		cmd.pop     = (state_q == dsdl_pkg::ST_DRAIN) && slot_free;
		start_drain = accept && mode && !status_i.empty;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dsdl_pkg::ST_IDLE: begin
				if (start_drain) state_d = dsdl_pkg::ST_DRAIN;
			end
			dsdl_pkg::ST_DRAIN: begin
				if (cmd.pop && status_i.one_left) state_d = dsdl_pkg::ST_IDLE;
			end
			default: state_d = dsdl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsdl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.drop || cmd.pop) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/dsdl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdl_datapath: sorted cell row and output register
// A row of cells kept in descending key order. An insert compares every
// cell at once and shifts the tail up by one; a pop shifts the row down.
// ----------------------------------------------------------------------------
module dsdl_datapath #(
	parameter int DEPTH     = 64,
	parameter int TAG_WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dsdl_pkg::dp_cmd_t    cmd,
	output dsdl_pkg::dp_status_t status_o,
	input  dsdl_pkg::key_t       depth_key,
	input  logic [TAG_WIDTH-1:0] record_tag,
	output logic [TAG_WIDTH-1:0] out_tag,
	output dsdl_pkg::key_t       out_key,
	output logic                 last,
	output logic                 status
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	dsdl_pkg::key_t       key_q  [DEPTH];
	logic [TAG_WIDTH-1:0] tag_q  [DEPTH];
	logic [DEPTH-1:0]     lt;
	logic [CNT_W-1:0]     count_q;

	logic [TAG_WIDTH-1:0] out_tag_q;
	dsdl_pkg::key_t       out_key_q;
	logic                 last_q;
	logic                 status_q;

	assign status_o.empty    = (count_q == '0);
	assign status_o.full     = (count_q == CNT_W'(DEPTH));
	assign status_o.one_left = (count_q == CNT_W'(1));

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dsdl_pkg::key_t       key_prev;
		logic [TAG_WIDTH-1:0] tag_prev;
		dsdl_pkg::key_t       key_next;
		logic [TAG_WIDTH-1:0] tag_next;
		logic                 lt_prev;
		logic                 shift_up;
		logic                 load_new;

		// A live cell holding a smaller key gives way to the new record.
		assign lt[i] = (CNT_W'(i) < count_q) && (key_q[i] < depth_key);

		if (i == 0) begin : g_head
			assign key_prev = depth_key;
			assign tag_prev = record_tag;
			assign lt_prev  = 1'b0;
		end else begin : g_body
			assign key_prev = key_q[i-1];
			assign tag_prev = tag_q[i-1];
			assign lt_prev  = lt[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign key_next = key_q[i];
			assign tag_next = tag_q[i];
		end else begin : g_inner
			assign key_next = key_q[i+1];
			assign tag_next = tag_q[i+1];
		end

		// The keys are in descending order, so lt is set on a contiguous tail of
		// the live cells; the new record goes to the first of them or to the end.
		assign shift_up = lt_prev;
		assign load_new = !lt_prev && (lt[i] || (count_q == CNT_W'(i)));

		always_ff @(posedge clk) begin
			if (cmd.insert) begin
				if (shift_up) begin
					key_q[i] <= key_prev;
					tag_q[i] <= tag_prev;
				end else if (load_new) begin
					key_q[i] <= depth_key;
					tag_q[i] <= record_tag;
				end
			end else if (cmd.pop) begin
				key_q[i] <= key_next;
				tag_q[i] <= tag_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drop) begin
			out_tag_q <= record_tag;
			out_key_q <= depth_key;
			last_q    <= 1'b0;
			status_q  <= 1'b1;
		end else if (cmd.pop) begin
			out_tag_q <= tag_q[0];
			out_key_q <= key_q[0];
			last_q    <= status_o.one_left;
			status_q  <= 1'b0;
		end
	end

	assign out_tag = out_tag_q;
	assign out_key = out_key_q;
	assign last    = last_q;
	assign status  = status_q;

endmodule

// ===== rtl/depth_sorted_draw_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_sorted_draw_list: bounded draw list sorted by depth key
// Inserts records in descending key order and drains them in one run.
// ----------------------------------------------------------------------------
// An insert compares every cell's key with the new one in parallel and the
// tail of the row shifts up, so inserts can follow each other on every clock
// while the input is not held off. Equal keys keep arrival order. A drain of
// N records returns one beat per cycle as long as the output is taken,
// and the input is held off until the beat flagged last has been loaded;
// a drain of an empty list returns nothing. An insert into a full list
// leaves the list as it was and returns one beat with status set and the
// dropped record's key and tag. The input is held off whenever the output
// register holds a beat that is not being taken. No clearing pass is needed
// after reset.
module depth_sorted_draw_list #(
	parameter int DEPTH     = 64,
	parameter int TAG_WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  logic signed [15:0]   depth_key,
	input  logic [TAG_WIDTH-1:0] record_tag,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [TAG_WIDTH-1:0] out_tag,
	output logic signed [15:0]   out_key,
	output logic                 last,
	output logic                 status
);

	dsdl_pkg::dp_cmd_t    cmd;
	dsdl_pkg::dp_status_t dp_status;

	dsdl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status_i (dp_status),
		.cmd      (cmd)
	);

	dsdl_datapath #(
		.DEPTH    (DEPTH),
		.TAG_WIDTH(TAG_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status_o  (dp_status),
		.depth_key (depth_key),
		.record_tag(record_tag),
		.out_tag   (out_tag),
		.out_key   (out_key),
		.last      (last),
		.status    (status)
	);

endmodule

// ===== rtl/dsdl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdl_checker: port level checks for the depth sorted draw list
// Watches the top level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module dsdl_checker #(
	parameter int TAG_WIDTH = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [TAG_WIDTH-1:0] out_tag,
	input logic signed [15:0]   out_key,
	input logic                 last,
	input logic                 status
);

	// An offered input beat stays offered until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input beat withdrawn before it was taken");

	// A stalled output beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_tag) && $stable(out_key)
			&& $stable(last) && $stable(status))
		else $error("output beat changed while stalled");

	// A dropped insert is never the end of a drain run.
	a_drop_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !last)
		else $error("dropped insert flagged last");

	// No input is taken while the output register is blocked.
	a_no_accept_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input ready while output stalled");

	// Mid drain the input stays held off.
	a_drain_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status && !last |-> !in_ready)
		else $error("input ready in the middle of a drain");

endmodule

bind depth_sorted_draw_list dsdl_checker #(
	.TAG_WIDTH(TAG_WIDTH)
) u_dsdl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_tag  (out_tag),
	.out_key  (out_key),
	.last     (last),
	.status   (status)
);
